[rtl/core/mtbl_pkg.sv]
`timescale 1ns / 1ps
package mtbl_pkg;

    localparam int FRAC_BITS = 7;
    localparam int FRAC_ONE  = 128;

    localparam int COORD_W = 16;            // axis bins, cells, coordinates
    localparam int FRAC_W  = 24;            // p, q and division numerator
    localparam int DEN_W   = 17;            // signed bin difference
    localparam int MAG_W   = 23;            // quotient magnitude
    localparam int OPND_W  = 25;            // shared multiplier operand
    localparam int PROD_W  = 2 * OPND_W;
    localparam int WGT_W   = 41;            // blend weight
    localparam int WLO_W   = 20;            // low slice of a weight
    localparam int ACC_W   = 62;
    localparam int MAC_STEPS = 12;

    typedef logic [1:0] op_t;
    localparam op_t OP_WRITE  = 2'd0;
    localparam op_t OP_READ   = 2'd1;
    localparam op_t OP_LOOKUP = 2'd2;

    typedef logic [1:0] region_t;
    localparam region_t RGN_CELL = 2'd0;
    localparam region_t RGN_X    = 2'd1;
    localparam region_t RGN_Y    = 2'd2;

    typedef struct packed {
        logic    rd_en;
        logic    wr_en;
        logic    wr_hi;
        region_t region;
        logic [7:0] wr_byte;
    } mem_cmd_t;

endpackage

[rtl/core/mtbl_req_if.sv]
`timescale 1ns / 1ps
interface mtbl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [1:0]  region;
    logic [8:0]  byte_offset;
    logic [7:0]  byte_value;
    logic [15:0] load_x;
    logic [15:0] load_y;

    modport source (output valid, operation, region, byte_offset, byte_value, load_x, load_y,
                    input ready);
    modport sink (input valid, operation, region, byte_offset, byte_value, load_x, load_y,
                  output ready);
endinterface

[rtl/core/mtbl_rsp_if.sv]
`timescale 1ns / 1ps
interface mtbl_rsp_if;
    logic               valid;
    logic               ready;
    logic [7:0]         read_byte;
    logic signed [31:0] interp_value;

    modport source (output valid, read_byte, interp_value, input ready);
    modport sink (input valid, read_byte, interp_value, output ready);
endinterface

[rtl/core/mtbl_store.sv]
`timescale 1ns / 1ps
module mtbl_store #(
    parameter int ROWS    = 16,
    parameter int COLUMNS = 16,
    localparam int CW     = $clog2(ROWS * COLUMNS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mtbl_pkg::mem_cmd_t cmd,
    input  logic [CW-1:0]      addr,
    output logic               busy,
    output logic [15:0]        cell_q,
    output logic [15:0]        x_q,
    output logic [15:0]        y_q
);
    import mtbl_pkg::*;

    localparam int N  = ROWS * COLUMNS;
    localparam int XW = $clog2(COLUMNS);
    localparam int YW = $clog2(ROWS);

    logic [7:0] cell_lo_mem [N];
    logic [7:0] cell_hi_mem [N];
    logic [7:0] x_lo_mem [COLUMNS];
    logic [7:0] x_hi_mem [COLUMNS];
    logic [7:0] y_lo_mem [ROWS];
    logic [7:0] y_hi_mem [ROWS];

    logic          busy_reg;
    logic [CW-1:0] clr_idx_reg;
    logic [15:0]   cell_q_reg;
    logic [15:0]   x_q_reg;
    logic [15:0]   y_q_reg;

    // zeroing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (32'(clr_idx_reg) == N - 1)
                busy_reg <= 1'b0;
            else
                clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            cell_lo_mem[clr_idx_reg] <= '0;
            cell_hi_mem[clr_idx_reg] <= '0;
            if (32'(clr_idx_reg) < COLUMNS)
            begin
                x_lo_mem[clr_idx_reg[XW-1:0]] <= '0;
                x_hi_mem[clr_idx_reg[XW-1:0]] <= '0;
            end
            if (32'(clr_idx_reg) < ROWS)
            begin
                y_lo_mem[clr_idx_reg[YW-1:0]] <= '0;
                y_hi_mem[clr_idx_reg[YW-1:0]] <= '0;
            end
        end
        else if (cmd.wr_en)
        begin
            case (cmd.region)
                RGN_CELL:
                begin
                    if (cmd.wr_hi)
                        cell_hi_mem[addr] <= cmd.wr_byte;
                    else
                        cell_lo_mem[addr] <= cmd.wr_byte;
                end
                RGN_X:
                begin
                    if (cmd.wr_hi)
                        x_hi_mem[addr[XW-1:0]] <= cmd.wr_byte;
                    else
                        x_lo_mem[addr[XW-1:0]] <= cmd.wr_byte;
                end
                RGN_Y:
                begin
                    if (cmd.wr_hi)
                        y_hi_mem[addr[YW-1:0]] <= cmd.wr_byte;
                    else
                        y_lo_mem[addr[YW-1:0]] <= cmd.wr_byte;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en && cmd.region == RGN_CELL)
            cell_q_reg <= {cell_hi_mem[addr], cell_lo_mem[addr]};
        if (cmd.rd_en && cmd.region == RGN_X)
            x_q_reg <= {x_hi_mem[addr[XW-1:0]], x_lo_mem[addr[XW-1:0]]};
        if (cmd.rd_en && cmd.region == RGN_Y)
            y_q_reg <= {y_hi_mem[addr[YW-1:0]], y_lo_mem[addr[YW-1:0]]};
    end

    assign busy   = busy_reg;
    assign cell_q = cell_q_reg;
    assign x_q    = x_q_reg;
    assign y_q    = y_q_reg;

endmodule

[rtl/core/mtbl_div.sv]
`timescale 1ns / 1ps
module mtbl_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [mtbl_pkg::FRAC_W-1:0]  num,
    input  logic signed [mtbl_pkg::DEN_W-1:0]   den,
    output logic                                busy,
    output logic                                done,
    output logic signed [mtbl_pkg::FRAC_W-1:0]  quo
);
    import mtbl_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    logic [MAG_W-1:0]   quo_reg;
    logic [15:0]        rem_reg;
    logic [15:0]        den_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [FRAC_W-1:0]  num_mag;
    logic [DEN_W-1:0]   den_mag;
    logic [16:0]        rem_sh;
    logic               ge;

    assign num_mag = num[FRAC_W-1] ? FRAC_W'(-num) : FRAC_W'(num);
    assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    assign rem_sh  = {rem_reg, quo_reg[MAG_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};

    // restoring, one quotient bit per cycle on magnitudes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            quo_reg <= num_mag[MAG_W-1:0];
            rem_reg <= '0;
            den_reg <= den_mag[15:0];
            neg_reg <= num[FRAC_W-1] ^ den[DEN_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[MAG_W-2:0], ge};
            rem_reg <= ge ? 16'(rem_sh - {1'b0, den_reg}) : rem_sh[15:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

[rtl/core/map_table_bilinear_lookup.sv]
`timescale 1ns / 1ps
// Two-dimensional map with bilinear interpolation. Each request word either writes or reads
// one byte of the cell grid (row-major, little-endian 16-bit elements), the ascending X axis
// or the descending Y axis, or looks up (load_x, load_y); every request returns exactly one
// response word. Byte accesses outside a region read 0 and writes there are dropped. A lookup
// walks each axis from the top bin down for an exact hit or a bracketing pair (bin 0 and the
// full axis span if none), forms 7-bit fractions with a shared divider (skipped when
// the two bins are equal), reads the four corner cells and blends them on one shared 25x25
// multiplier; the result saturates to 32 bits signed. One word is in work at a time; the
// worst-case lookup time is set by the serial bin walk on the one store read port and the
// bit-serial divider. After reset the stores are zeroed one entry per cycle, and no request
// is taken meanwhile. A finished response sits in an output register, so the next request
// is taken while it waits.
module map_table_bilinear_lookup #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mtbl_req_if.sink   request,
    mtbl_rsp_if.source response
);
    import mtbl_pkg::*;

    localparam int N    = ROWS * COLUMNS;
    localparam int CW   = $clog2(N);
    localparam int MAXD = (ROWS > COLUMNS) ? ROWS : COLUMNS;
    localparam int SW   = $clog2(MAXD);

    typedef enum logic [13:0] {
        S_IDLE = 14'h0001,
        S_WR   = 14'h0002,
        S_RD   = 14'h0004,
        S_RDW  = 14'h0008,
        S_XS   = 14'h0010,
        S_YS   = 14'h0020,
        S_SRCH = 14'h0040,
        S_PS   = 14'h0080,
        S_PW   = 14'h0100,
        S_QS   = 14'h0200,
        S_QW   = 14'h0400,
        S_CELL = 14'h0800,
        S_MAC  = 14'h1000,
        S_FIN  = 14'h2000
    } state_t;

    state_t state_reg, state_next;

    // latched request
    op_t         op_reg;
    region_t     region_reg;
    logic [8:0]  off_reg;
    logic [7:0]  val_reg;
    logic [15:0] lx_reg;
    logic [15:0] ly_reg;

    // axis walk
    logic          axis_y_reg;
    logic          first_reg;
    logic [SW-1:0] k_reg;
    logic [15:0]   hi_reg;
    logic [15:0]   top_reg;
    logic [15:0]   x_lov_reg, x_hiv_reg, y_lov_reg, y_hiv_reg;
    logic [SW-1:0] x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg;

    logic signed [FRAC_W-1:0] p_reg, q_reg;
    logic [2:0]   c_reg;
    logic [15:0]  corner_reg [4];
    logic [3:0]   s_reg;
    logic signed [WGT_W-1:0]  w_reg [4];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [7:0]   res_byte_reg;

    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic signed [31:0] out_val_reg;

    mem_cmd_t      cmd;
    logic [CW-1:0] mem_addr;
    logic          store_busy;
    logic [15:0]   cell_q, x_q, y_q;

    logic                     div_start, div_busy, div_done;
    logic signed [FRAC_W-1:0] div_num, div_quo;
    logic signed [DEN_W-1:0]  div_den;

    logic [7:0]  idx;
    logic        in_range;
    logic        accept;
    logic [15:0] v, sq, q16;
    logic        hit_eq, hit_br, hit, walk_end;
    logic [SW-1:0] r_hi;
    logic [DEN_W-1:0] x_diff, yl_diff, yh_diff, x_den, y_den;
    logic signed [FRAC_W-1:0] p_num, q_num;
    logic        x_eq, y_eq;
    logic [1:0]  cj;
    logic [SW-1:0] row, col;
    logic signed [OPND_W-1:0] om, oq, p25, q25, mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [3:0]  sk, t;
    logic [1:0]  ki;
    logic signed [ACC_W-1:0] sum;
    logic        ovf;
    logic signed [31:0] sat_val;

    assign accept  = request.valid && request.ready;
    assign request.ready = (state_reg == S_IDLE) && !store_busy;

    // byte access range check
    assign idx = off_reg[8:1];
    always_comb
    begin
        case (region_reg)
            RGN_CELL: in_range = 32'(idx) < N;
            RGN_X:    in_range = 32'(idx) < COLUMNS;
            RGN_Y:    in_range = 32'(idx) < ROWS;
            default:  in_range = 1'b0;
        endcase
    end

    // shared bin compare
    assign v      = axis_y_reg ? ly_reg : lx_reg;
    assign sq     = axis_y_reg ? y_q : x_q;
    assign hit_eq = v == sq;
    assign hit_br = axis_y_reg ? (v >= hi_reg && v <= sq) : (v >= sq && v <= hi_reg);
    assign hit    = !first_reg && (hit_eq || hit_br);
    assign walk_end = hit || (!first_reg && k_reg == '0);
    assign r_hi   = (hit_br && !hit_eq) ? SW'(k_reg + 1'b1) : k_reg;

    // fraction operands
    assign x_diff  = {1'b0, lx_reg} - {1'b0, x_lov_reg};
    assign yl_diff = {1'b0, ly_reg} - {1'b0, y_lov_reg};
    assign yh_diff = {1'b0, ly_reg} - {1'b0, y_hiv_reg};
    assign x_den   = {1'b0, x_hiv_reg} - {1'b0, x_lov_reg};
    assign y_den   = {1'b0, y_lov_reg} - {1'b0, y_hiv_reg};
    assign x_eq    = x_hiv_reg == x_lov_reg;
    assign y_eq    = y_hiv_reg == y_lov_reg;
    assign p_num   = {x_diff, {FRAC_BITS{1'b0}}};
    assign q_num   = y_eq ? {yl_diff, {FRAC_BITS{1'b0}}} : {yh_diff, {FRAC_BITS{1'b0}}};

    assign div_start = (state_reg == S_PS && !x_eq) || (state_reg == S_QS && !y_eq);
    assign div_num   = (state_reg == S_PS) ? p_num : q_num;
    assign div_den   = (state_reg == S_PS) ? $signed(x_den) : $signed(y_den);

    // corner order: (ylo,xlo) (ylo,xhi) (yhi,xlo) (yhi,xhi)
    assign cj  = c_reg[1:0];
    assign row = cj[1] ? y_hi_reg : y_lo_reg;
    assign col = cj[0] ? x_hi_reg : x_lo_reg;

    // shared multiplier: steps 0-3 weights, 4-11 corner x weight halves
    assign om  = OPND_W'(FRAC_ONE) - OPND_W'(p_reg);
    assign oq  = OPND_W'(FRAC_ONE) - OPND_W'(q_reg);
    assign p25 = OPND_W'(p_reg);
    assign q25 = OPND_W'(q_reg);
    assign sk  = s_reg - 4'd4;
    assign ki  = sk[2:1];
    assign t   = s_reg - 4'd1;

    always_comb
    begin
        mul_a = om;
        mul_b = oq;
        case (s_reg)
            4'd0:
            begin
                mul_a = om;
                mul_b = oq;
            end
            4'd1:
            begin
                mul_a = p25;
                mul_b = oq;
            end
            4'd2:
            begin
                mul_a = om;
                mul_b = q25;
            end
            4'd3:
            begin
                mul_a = p25;
                mul_b = q25;
            end
            default:
            begin
                mul_a = $signed({{(OPND_W - 16){1'b0}}, corner_reg[ki]});
                if (s_reg[0])
                    mul_b = OPND_W'($signed(w_reg[ki][WGT_W-1:WLO_W]));
                else
                    mul_b = $signed({{(OPND_W - WLO_W){1'b0}}, w_reg[ki][WLO_W-1:0]});
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // floor by 128 and saturate
    assign sum     = acc_reg >>> FRAC_BITS;
    assign ovf     = !((&sum[ACC_W-1:31]) || !(|sum[ACC_W-1:31]));
    assign sat_val = ovf ? (sum[ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff) : sum[31:0];

    // store port
    always_comb
    begin
        cmd      = '0;
        mem_addr = '0;
        unique case (state_reg)
            S_WR:
            begin
                cmd.wr_en   = in_range;
                cmd.region  = region_reg;
                cmd.wr_hi   = off_reg[0];
                cmd.wr_byte = val_reg;
                mem_addr    = CW'(idx);
            end
            S_RD:
            begin
                cmd.rd_en  = in_range;
                cmd.region = region_reg;
                mem_addr   = CW'(idx);
            end
            S_XS:
            begin
                cmd.rd_en  = 1'b1;
                cmd.region = RGN_X;
                mem_addr   = CW'(COLUMNS - 1);
            end
            S_YS:
            begin
                cmd.rd_en  = 1'b1;
                cmd.region = RGN_Y;
                mem_addr   = CW'(ROWS - 1);
            end
            S_SRCH:
            begin
                cmd.rd_en  = !walk_end;
                cmd.region = axis_y_reg ? RGN_Y : RGN_X;
                mem_addr   = CW'(SW'(k_reg - 1'b1));
            end
            S_CELL:
            begin
                cmd.rd_en  = !c_reg[2];
                cmd.region = RGN_CELL;
                mem_addr   = CW'(CW'(row) * CW'(COLUMNS) + CW'(col));
            end
            S_IDLE, S_RDW, S_PS, S_PW, S_QS, S_QW, S_MAC, S_FIN:
            begin
            end
        endcase
    end

    assign q16 = (region_reg == RGN_CELL) ? cell_q : ((region_reg == RGN_X) ? x_q : y_q);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (request.operation)
                        OP_WRITE:  state_next = S_WR;
                        OP_READ:   state_next = S_RD;
                        OP_LOOKUP: state_next = S_XS;
                        default:   state_next = S_FIN;
                    endcase
                end
            end
            S_WR:   state_next = S_FIN;
            S_RD:   state_next = S_RDW;
            S_RDW:  state_next = S_FIN;
            S_XS:   state_next = S_SRCH;
            S_YS:   state_next = S_SRCH;
            S_SRCH:
            begin
                if (walk_end)
                    state_next = axis_y_reg ? S_PS : S_YS;
            end
            S_PS:   state_next = x_eq ? S_QS : S_PW;
            S_PW:
            begin
                if (div_done)
                    state_next = S_QS;
            end
            S_QS:   state_next = y_eq ? S_CELL : S_QW;
            S_QW:
            begin
                if (div_done)
                    state_next = S_CELL;
            end
            S_CELL:
            begin
                if (c_reg == 3'd4)
                    state_next = S_MAC;
            end
            S_MAC:
            begin
                if (s_reg == 4'(MAC_STEPS))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || response.ready)
                    state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FIN && (!out_valid_reg || response.ready))
                out_valid_reg <= 1'b1;
            else if (response.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= request.operation;
            region_reg   <= request.region;
            off_reg      <= request.byte_offset;
            val_reg      <= request.byte_value;
            lx_reg       <= request.load_x;
            ly_reg       <= request.load_y;
            res_byte_reg <= '0;
            acc_reg      <= '0;
        end

        if (state_reg == S_RDW && in_range)
            res_byte_reg <= off_reg[0] ? q16[15:8] : q16[7:0];

        if (state_reg == S_XS || state_reg == S_YS)
        begin
            axis_y_reg <= (state_reg == S_YS);
            first_reg  <= 1'b1;
            k_reg      <= (state_reg == S_YS) ? SW'(ROWS - 1) : SW'(COLUMNS - 1);
        end

        if (state_reg == S_SRCH)
        begin
            first_reg <= 1'b0;
            if (first_reg)
                top_reg <= sq;
            if (walk_end)
            begin
                if (axis_y_reg)
                begin
                    y_lov_reg <= sq;
                    y_hiv_reg <= hit_eq ? sq : (hit_br ? hi_reg : top_reg);
                    y_lo_reg  <= k_reg;
                    y_hi_reg  <= r_hi;
                end
                else
                begin
                    x_lov_reg <= sq;
                    x_hiv_reg <= hit_eq ? sq : (hit_br ? hi_reg : top_reg);
                    x_lo_reg  <= k_reg;
                    x_hi_reg  <= r_hi;
                end
            end
            else
            begin
                hi_reg <= sq;
                k_reg  <= SW'(k_reg - 1'b1);
            end
        end

        if (state_reg == S_PS && x_eq)
            p_reg <= p_num;
        if (state_reg == S_PW && div_done)
            p_reg <= div_quo;
        if (state_reg == S_QS)
        begin
            c_reg <= '0;
            if (y_eq)
                q_reg <= q_num;
        end
        if (state_reg == S_QW && div_done)
        begin
            q_reg <= div_quo;
            c_reg <= '0;
        end

        if (state_reg == S_CELL)
        begin
            c_reg <= c_reg + 1'b1;
            if (c_reg != 3'd0)
                corner_reg[2'(c_reg - 1'b1)] <= cell_q;
            s_reg <= '0;
        end

        if (state_reg == S_MAC)
        begin
            prod_reg <= mul_p;
            s_reg    <= s_reg + 1'b1;
            if (s_reg != 4'd0)
            begin
                if (t < 4'd4)
                    w_reg[t[1:0]] <= WGT_W'(prod_reg >>> FRAC_BITS);
                else if (!t[0])
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                else
                    acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< WLO_W);
            end
        end

        if (state_reg == S_FIN && (!out_valid_reg || response.ready))
        begin
            out_byte_reg <= res_byte_reg;
            out_val_reg  <= (op_reg == OP_LOOKUP) ? sat_val : 32'sd0;
        end
    end

    assign response.valid        = out_valid_reg;
    assign response.read_byte    = out_byte_reg;
    assign response.interp_value = out_val_reg;

    mtbl_store #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .addr   (mem_addr),
        .busy   (store_busy),
        .cell_q (cell_q),
        .x_q    (x_q),
        .y_q    (y_q)
    );

    mtbl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> !request.ready)
        else $error("request taken during store clear");

    a_one_word_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !request.ready)
        else $error("second request taken while one is in work");

    a_mac_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (s_reg <= 4'(MAC_STEPS)))
        else $error("blend step counter overran");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

endmodule
